/* src/bst_pkg.sv */
// Package for the breakpoint site table.
// Holds the site record, the result record, operation and status codes.
// No dependencies.
`default_nettype none
package bst_pkg;

    localparam int DefSiteDepth = 16;
    localparam int MaxResults   = 16;

    localparam logic [2:0] kTypePermanent         = 3'd1;
    localparam logic [2:0] kTypeTemporaryOneShot  = 3'd2;
    localparam logic [2:0] kTypeTemporaryUntilHit = 3'd4;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_HAS     = 3'd2;
    localparam logic [2:0] OP_HIT     = 3'd3;
    localparam logic [2:0] OP_ENABLE  = 3'd4;
    localparam logic [2:0] OP_DISABLE = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVAL    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [63:0] address;
        logic [2:0]  kind;
        logic [1:0]  access;
        logic [3:0]  length;
        logic [7:0]  count;
    } site_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        site_t      site;
        logic       arm;
        logic       disarm;
        logic       last;
    } res_t;

    function automatic res_t make_res(logic [1:0] status, logic found, site_t site,
                                      logic arm, logic disarm, logic last);
        res_t r;
        r.status = status;
        r.found  = found;
        r.site   = found ? site : '0;
        r.arm    = arm;
        r.disarm = disarm;
        r.last   = last;
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/bst_site_mem.sv */
// Site record memory: one write port and one registered read port.
// Depends on bst_pkg for the site record type.
`default_nettype none
module bst_site_mem #(
    parameter int DEPTH = 16,
    parameter int IDXW  = 4
) (
    input  wire                  clk,
    input  wire                  wr_en,
    input  wire [IDXW-1:0]       wr_idx,
    input  bst_pkg::site_t       wr_data,
    input  wire                  rd_en,
    input  wire [IDXW-1:0]       rd_idx,
    output bst_pkg::site_t       rd_data
);
    import bst_pkg::*;

    site_t site_mem [DEPTH];
    site_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            site_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= site_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

/* src/breakpoint_site_table.sv */
// Top level of the breakpoint site table: control sequencer and result register.
// Depends on bst_pkg and bst_site_mem.
//
// A command is taken at a rising edge where start is high and busy is low.
// Results appear on the result ports for one cycle each, marked by
// result_valid; last marks the final result of a command. The receiver
// cannot stall, so no backpressure exists.
// Invalid-argument commands, clear and unused codes answer in the cycle after
// acceptance without raising busy.
// Add, remove, has and hit scan the site memory one entry per cycle through
// its single read port.
// Enable and disable run one full scan of the memory per reported site to
// find the next address in ascending order; disable then makes another pass
// over the memory, updating every valid entry.
// Reset clears every valid bit and the armed flag; the record memory needs
// no clearing pass, and the block takes commands right after reset.
`default_nettype none
module breakpoint_site_table #(
    parameter int SITE_DEPTH = bst_pkg::DefSiteDepth
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  mode,
    input  wire  [63:0] address,
    input  wire         address_ok,
    input  wire  [2:0]  kind_bits,
    input  wire  [1:0]  access_kind,
    input  wire  [3:0]  length,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic        found,
    output logic [63:0] site_address,
    output logic [2:0]  site_kind,
    output logic [1:0]  site_access,
    output logic [3:0]  site_length,
    output logic [7:0]  site_count,
    output logic        arm_request,
    output logic        disarm_request,
    output logic        last
);
    import bst_pkg::*;

    localparam int IDXW = (SITE_DEPTH > 1) ? $clog2(SITE_DEPTH) : 1;
    localparam int CNTW = $clog2(SITE_DEPTH + 1);
    localparam int SHW  = $clog2(MaxResults + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [2:0]            op_mode_reg, op_mode_next;
    site_t                 op_reg, op_next;
    logic [SITE_DEPTH-1:0] valid_reg, valid_next;
    logic                  armed_reg, armed_next;
    logic [CNTW-1:0]       issue_reg, issue_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IDXW-1:0]       chk_idx_reg, chk_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [IDXW-1:0]       free_idx_reg, free_idx_next;
    logic                  hit_found_reg, hit_found_next;
    logic [IDXW-1:0]       hit_idx_reg, hit_idx_next;
    site_t                 hit_rec_reg, hit_rec_next;
    logic [63:0]           prev_addr_reg, prev_addr_next;
    logic                  have_prev_reg, have_prev_next;
    logic                  best_found_reg, best_found_next;
    site_t                 best_rec_reg, best_rec_next;
    logic [CNTW-1:0]       cand_reg, cand_next;
    logic [SHW-1:0]        shown_reg, shown_next;
    logic                  res_vld_reg, res_vld_next;
    res_t                  res_reg, res_next;

    logic            wr_en;
    logic [IDXW-1:0] wr_idx;
    site_t           wr_data;
    logic            rd_en;
    site_t           rd_data;
    logic            scan_last;
    logic            enabling;
    logic            is_last;
    site_t           upd;
    logic [7:0]      cnt_dec;

    bst_site_mem #(
        .DEPTH (SITE_DEPTH),
        .IDXW  (IDXW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (issue_reg[IDXW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_en     = ((state_reg == S_SCAN) || (state_reg == S_UPD))
                       && (issue_reg < CNTW'(SITE_DEPTH));
    assign scan_last = chk_vld_reg && (chk_idx_reg == IDXW'(SITE_DEPTH - 1));
    assign enabling  = (op_mode_reg == OP_ENABLE);

    always_comb
    begin
        state_next      = state_reg;
        op_mode_next    = op_mode_reg;
        op_next         = op_reg;
        valid_next      = valid_reg;
        armed_next      = armed_reg;
        issue_next      = issue_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rec_next    = hit_rec_reg;
        prev_addr_next  = prev_addr_reg;
        have_prev_next  = have_prev_reg;
        best_found_next = best_found_reg;
        best_rec_next   = best_rec_reg;
        cand_next       = cand_reg;
        shown_next      = shown_reg;
        res_vld_next    = 1'b0;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_idx          = hit_idx_reg;
        wr_data         = hit_rec_reg;
        is_last         = 1'b0;
        upd             = hit_rec_reg;
        cnt_dec         = 8'd0;

        if (rd_en)
        begin
            chk_vld_next = 1'b1;
            chk_idx_next = issue_reg[IDXW-1:0];
            issue_next   = issue_reg + CNTW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_mode_next    = mode;
                    op_next.address = address;
                    op_next.kind    = kind_bits;
                    op_next.access  = access_kind;
                    op_next.length  = length;
                    op_next.count   = 8'd0;
                    issue_next      = '0;
                    free_found_next = 1'b0;
                    hit_found_next  = 1'b0;
                    have_prev_next  = 1'b0;
                    best_found_next = 1'b0;
                    cand_next       = '0;
                    shown_next      = '0;
                    case (mode) inside
                        OP_ADD, OP_REMOVE, OP_HAS, OP_HIT:
                        begin
                            if (address_ok)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                res_vld_next = 1'b1;
                                res_next = make_res(ST_INVAL, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                            end
                        end
                        OP_ENABLE, OP_DISABLE:
                        begin
                            armed_next = (mode == OP_ENABLE);
                            state_next = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            valid_next   = '0;
                            res_vld_next = 1'b1;
                            res_next = make_res(ST_OK, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                        default:
                        begin
                            res_vld_next = 1'b1;
                            res_next = make_res(ST_INVAL, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if ((op_mode_reg == OP_ENABLE) || (op_mode_reg == OP_DISABLE))
                begin
                    if (chk_vld_reg && valid_reg[chk_idx_reg]
                        && (!have_prev_reg || (rd_data.address > prev_addr_reg)))
                    begin
                        cand_next = cand_reg + CNTW'(1);
                        if (!best_found_reg || (rd_data.address < best_rec_reg.address))
                        begin
                            best_found_next = 1'b1;
                            best_rec_next   = rd_data;
                        end
                    end
                    if (scan_last)
                    begin
                        res_vld_next = 1'b1;
                        if (!best_found_next)
                        begin
                            res_next = make_res(ST_OK, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                            is_last  = 1'b1;
                        end
                        else
                        begin
                            is_last = (cand_next == CNTW'(1))
                                      || (shown_reg == SHW'(MaxResults - 1));
                            upd = best_rec_next;
                            if (!enabling)
                            begin
                                upd.kind = best_rec_next.kind & ~kTypeTemporaryOneShot;
                            end
                            res_next = make_res(ST_OK, 1'b1, upd, enabling, !enabling,
                                                is_last);
                            shown_next      = shown_reg + SHW'(1);
                            prev_addr_next  = best_rec_next.address;
                            have_prev_next  = 1'b1;
                            best_found_next = 1'b0;
                            cand_next       = '0;
                        end
                        issue_next   = '0;
                        chk_vld_next = 1'b0;
                        if (is_last)
                        begin
                            state_next = enabling ? S_IDLE : S_UPD;
                        end
                    end
                end
                else if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg] && (rd_data.address == op_reg.address))
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_rec_next   = rd_data;
                        state_next     = S_ACT;
                    end
                    else
                    begin
                        if (!valid_reg[chk_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (scan_last)
                        begin
                            state_next = S_ACT;
                        end
                    end
                end
            end

            S_ACT:
            begin
                state_next   = S_IDLE;
                res_vld_next = 1'b1;
                upd          = hit_rec_reg;
                case (op_mode_reg)
                    OP_ADD:
                    begin
                        if (hit_found_reg)
                        begin
                            if (hit_rec_reg.access != op_reg.access)
                            begin
                                res_next = make_res(ST_INVAL, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                            end
                            else if ((op_reg.kind == kTypePermanent)
                                     && (hit_rec_reg.count == 8'd255))
                            begin
                                res_next = make_res(ST_FULL, 1'b1, hit_rec_reg, 1'b0, 1'b0,
                                                    1'b1);
                            end
                            else
                            begin
                                upd.kind = hit_rec_reg.kind | op_reg.kind;
                                if (op_reg.kind == kTypePermanent)
                                begin
                                    upd.count = hit_rec_reg.count + 8'd1;
                                end
                                wr_en    = 1'b1;
                                wr_data  = upd;
                                res_next = make_res(ST_OK, 1'b1, upd, 1'b0, 1'b0, 1'b1);
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            res_next = make_res(ST_FULL, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            upd       = op_reg;
                            upd.count = (op_reg.kind == kTypePermanent) ? 8'd1 : 8'd0;
                            wr_en     = 1'b1;
                            wr_idx    = free_idx_reg;
                            wr_data   = upd;
                            valid_next[free_idx_reg] = 1'b1;
                            res_next = make_res(ST_OK, 1'b1, upd, armed_reg, 1'b0, 1'b1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_next = make_res(ST_NOTFOUND, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                        else if ((hit_rec_reg.kind & kTypePermanent) != 3'd0)
                        begin
                            cnt_dec   = (hit_rec_reg.count != 8'd0) ? hit_rec_reg.count - 8'd1
                                                                    : 8'd0;
                            upd.count = cnt_dec;
                            if (cnt_dec != 8'd0)
                            begin
                                wr_en    = 1'b1;
                                wr_data  = upd;
                                res_next = make_res(ST_OK, 1'b1, upd, 1'b0, 1'b0, 1'b1);
                            end
                            else if (hit_rec_reg.kind != kTypePermanent)
                            begin
                                upd.kind = hit_rec_reg.kind & ~kTypePermanent;
                                wr_en    = 1'b1;
                                wr_data  = upd;
                                res_next = make_res(ST_OK, 1'b1, upd, 1'b0, 1'b0, 1'b1);
                            end
                            else
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                res_next = make_res(ST_OK, 1'b1, upd, 1'b0, armed_reg, 1'b1);
                            end
                        end
                        else
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            res_next = make_res(ST_OK, 1'b1, upd, 1'b0, armed_reg, 1'b1);
                        end
                    end
                    default:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_next = make_res(ST_NOTFOUND, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            if (op_mode_reg == OP_HIT)
                            begin
                                upd.kind = hit_rec_reg.kind & ~kTypeTemporaryUntilHit;
                                wr_en    = 1'b1;
                                wr_data  = upd;
                            end
                            res_next = make_res(ST_OK, 1'b1, upd, 1'b0, 1'b0, 1'b1);
                        end
                    end
                endcase
            end

            S_UPD:
            begin
                if (chk_vld_reg && valid_reg[chk_idx_reg])
                begin
                    upd      = rd_data;
                    upd.kind = rd_data.kind & ~kTypeTemporaryOneShot;
                    wr_en    = 1'b1;
                    wr_idx   = chk_idx_reg;
                    wr_data  = upd;
                    if (upd.kind == 3'd0)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                    end
                end
                if (scan_last)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            armed_reg   <= 1'b0;
            chk_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            armed_reg   <= armed_next;
            chk_vld_reg <= chk_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg    <= op_mode_next;
        op_reg         <= op_next;
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rec_reg    <= hit_rec_next;
        prev_addr_reg  <= prev_addr_next;
        have_prev_reg  <= have_prev_next;
        best_found_reg <= best_found_next;
        best_rec_reg   <= best_rec_next;
        cand_reg       <= cand_next;
        shown_reg      <= shown_next;
        res_reg        <= res_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = res_vld_reg;
    assign status         = res_reg.status;
    assign found          = res_reg.found;
    assign site_address   = res_reg.site.address;
    assign site_kind      = res_reg.site.kind;
    assign site_access    = res_reg.site.access;
    assign site_length    = res_reg.site.length;
    assign site_count     = res_reg.site.count;
    assign arm_request    = res_reg.arm;
    assign disarm_request = res_reg.disarm;
    assign last           = res_reg.last;
endmodule
`default_nettype wire

/* src/bst_checker.sv */
// Port-level checks for the breakpoint site table, bound to the top level.
// Depends on bst_pkg for status codes.
`default_nettype none
module bst_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        result_valid,
    input wire [1:0]  status,
    input wire        found,
    input wire [63:0] site_address,
    input wire        arm_request,
    input wire        disarm_request
);
    import bst_pkg::*;

    a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(arm_request && disarm_request))
        else $error("Arm and disarm requested together.");

    a_no_site_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (site_address == 64'd0))
        else $error("Site address nonzero without a site.");

    a_err_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_OK)) |-> (!arm_request && !disarm_request))
        else $error("Request raised on a failed transaction.");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && found) |-> ((status == ST_OK) || (status == ST_FULL)))
        else $error("Site reported with an error status.");
endmodule

bind breakpoint_site_table bst_checker u_bst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .status         (status),
    .found          (found),
    .site_address   (site_address),
    .arm_request    (arm_request),
    .disarm_request (disarm_request)
);
`default_nettype wire

/* tb/sv/breakpoint_site_table_checker.sv */
// Checker for the breakpoint site table: predicts the results of every accepted command
// and compares them in order with the results that the block reports.
// Depends on bst_pkg.
`timescale 1ns / 1ps
module breakpoint_site_table_checker
    import bst_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire  [2:0]  mode,
    input  wire  [63:0] address,
    input  wire         address_ok,
    input  wire  [2:0]  kind_bits,
    input  wire  [1:0]  access_kind,
    input  wire  [3:0]  length,
    input  wire         result_valid,
    input  wire  [1:0]  status,
    input  wire         found,
    input  wire  [63:0] site_address,
    input  wire  [2:0]  site_kind,
    input  wire  [1:0]  site_access,
    input  wire  [3:0]  site_length,
    input  wire  [7:0]  site_count,
    input  wire         arm_request,
    input  wire         disarm_request,
    input  wire         last,
    output int          mismatches,
    output int          pending
);
    localparam int Depth = DefSiteDepth;

    logic        site_used [Depth];
    site_t       site_rec  [Depth];
    logic        sites_armed;
    res_t        expected_results [$];

    task automatic push_result(logic [1:0] st, int idx, logic arm, logic disarm, logic fin);
        res_t r;
        r = '0;
        r.status = st;
        if (idx >= 0) begin
            r.found = 1'b1;
            r.site  = site_rec[idx];
        end
        r.arm    = arm;
        r.disarm = disarm;
        r.last   = fin;
        expected_results.push_back(r);
    endtask

    function automatic int find_site(logic [63:0] a);
        for (int i = 0; i < Depth; i++)
            if (site_used[i] && site_rec[i].address == a)
                return i;
        return -1;
    endfunction

    task automatic sweep_sites(logic enabling);
        logic taken [Depth];
        int   order [$];
        int   best;
        int   shown;
        sites_armed = enabling;
        for (int i = 0; i < Depth; i++)
            taken[i] = 1'b0;
        forever begin
            best = -1;
            for (int i = 0; i < Depth; i++)
                if (site_used[i] && !taken[i] &&
                    (best < 0 || site_rec[i].address < site_rec[best].address))
                    best = i;
            if (best < 0)
                break;
            taken[best] = 1'b1;
            order.push_back(best);
        end
        if (order.size() == 0) begin
            push_result(ST_OK, -1, 1'b0, 1'b0, 1'b1);
            return;
        end
        shown = order.size() < MaxResults ? order.size() : MaxResults;
        for (int k = 0; k < order.size(); k++) begin
            if (!enabling)
                site_rec[order[k]].kind = site_rec[order[k]].kind & ~kTypeTemporaryOneShot;
            if (k < shown)
                push_result(ST_OK, order[k], enabling, !enabling, k == shown - 1);
            if (!enabling && site_rec[order[k]].kind == 3'd0)
                site_used[order[k]] = 1'b0;
        end
    endtask

    task automatic predict_command();
        int idx;
        case (mode)
            OP_ADD: begin
                idx = find_site(address);
                if (!address_ok)
                    push_result(ST_INVAL, -1, 1'b0, 1'b0, 1'b1);
                else if (idx >= 0) begin
                    if (site_rec[idx].access != access_kind)
                        push_result(ST_INVAL, -1, 1'b0, 1'b0, 1'b1);
                    else if (kind_bits == kTypePermanent && site_rec[idx].count == 8'd255)
                        push_result(ST_FULL, idx, 1'b0, 1'b0, 1'b1);
                    else begin
                        if (kind_bits == kTypePermanent)
                            site_rec[idx].count++;
                        site_rec[idx].kind |= kind_bits;
                        push_result(ST_OK, idx, 1'b0, 1'b0, 1'b1);
                    end
                end else begin
                    idx = -1;
                    for (int i = Depth - 1; i >= 0; i--)
                        if (!site_used[i])
                            idx = i;
                    if (idx < 0)
                        push_result(ST_FULL, -1, 1'b0, 1'b0, 1'b1);
                    else begin
                        site_used[idx] = 1'b1;
                        site_rec[idx].address = address;
                        site_rec[idx].kind    = kind_bits;
                        site_rec[idx].access  = access_kind;
                        site_rec[idx].length  = length;
                        site_rec[idx].count   = (kind_bits == kTypePermanent) ? 8'd1 : 8'd0;
                        push_result(ST_OK, idx, sites_armed, 1'b0, 1'b1);
                    end
                end
            end
            OP_REMOVE: begin
                idx = find_site(address);
                if (!address_ok)
                    push_result(ST_INVAL, -1, 1'b0, 1'b0, 1'b1);
                else if (idx < 0)
                    push_result(ST_NOTFOUND, -1, 1'b0, 1'b0, 1'b1);
                else if ((site_rec[idx].kind & kTypePermanent) != 3'd0 &&
                         (site_rec[idx].count > 8'd1 || site_rec[idx].kind != kTypePermanent))
                begin
                    if (site_rec[idx].count > 8'd0)
                        site_rec[idx].count--;
                    if (site_rec[idx].count == 8'd0)
                        site_rec[idx].kind &= ~kTypePermanent;
                    push_result(ST_OK, idx, 1'b0, 1'b0, 1'b1);
                end else begin
                    if ((site_rec[idx].kind & kTypePermanent) != 3'd0)
                        site_rec[idx].count = 8'd0;
                    push_result(ST_OK, idx, 1'b0, sites_armed, 1'b1);
                    site_used[idx] = 1'b0;
                end
            end
            OP_HAS, OP_HIT: begin
                idx = find_site(address);
                if (!address_ok)
                    push_result(ST_INVAL, -1, 1'b0, 1'b0, 1'b1);
                else if (idx < 0)
                    push_result(ST_NOTFOUND, -1, 1'b0, 1'b0, 1'b1);
                else begin
                    if (mode == OP_HIT)
                        site_rec[idx].kind &= ~kTypeTemporaryUntilHit;
                    push_result(ST_OK, idx, 1'b0, 1'b0, 1'b1);
                end
            end
            OP_ENABLE:  sweep_sites(1'b1);
            OP_DISABLE: sweep_sites(1'b0);
            OP_CLEAR: begin
                for (int i = 0; i < Depth; i++)
                    site_used[i] = 1'b0;
                push_result(ST_OK, -1, 1'b0, 1'b0, 1'b1);
            end
            default: push_result(ST_INVAL, -1, 1'b0, 1'b0, 1'b1);
        endcase
    endtask

    task automatic check_result();
        res_t want;
        res_t got;
        got = '0;
        got.status       = status;
        got.found        = found;
        got.site.address = site_address;
        got.site.kind    = site_kind;
        got.site.access  = site_access;
        got.site.length  = site_length;
        got.site.count   = site_count;
        got.arm          = arm_request;
        got.disarm       = disarm_request;
        got.last         = last;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction: %p", got);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.site.address !== want.site.address || got.site.kind !== want.site.kind ||
            got.site.access !== want.site.access || got.site.length !== want.site.length ||
            got.site.count !== want.site.count || got.arm !== want.arm ||
            got.disarm !== want.disarm || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected %p, actual %p", want, got);
        end
    endtask

    initial begin
        mismatches  = 0;
        pending     = 0;
        sites_armed = 1'b0;
        for (int i = 0; i < Depth; i++) begin
            site_used[i] = 1'b0;
            site_rec[i]  = '0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid)
                check_result();
            if (start && !busy)
                predict_command();
            pending = expected_results.size();
        end
    end
endmodule

/* tb/sv/breakpoint_site_table_test.sv */
// Top of the breakpoint site table testbench: clock, reset, command stimulus and verdict.
// Depends on bst_pkg, breakpoint_site_table and breakpoint_site_table_checker.
`timescale 1ns / 1ps
module breakpoint_site_table_test;
    import bst_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  mode = OP_CLEAR;
    logic [63:0] address = '0;
    logic        address_ok = 1'b0;
    logic [2:0]  kind_bits = '0;
    logic [1:0]  access_kind = '0;
    logic [3:0]  length = '0;
    wire         busy, result_valid, found, arm_request, disarm_request, last;
    wire  [1:0]  status, site_access;
    wire  [63:0] site_address;
    wire  [2:0]  site_kind;
    wire  [3:0]  site_length;
    wire  [7:0]  site_count;
    int          mismatches, pending;
    int          cycles = 0;
    int          idle_pct = 0;
    logic [63:0] addr_pool [24];

    breakpoint_site_table dut (.*);
    breakpoint_site_table_checker checker_i (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > 600000) begin
            $display("breakpoint_site_table_test failed");
            $finish;
        end
    end

    task automatic issue(logic [2:0] m, logic [63:0] a, logic ok, logic [2:0] k,
                         logic [1:0] acc, logic [3:0] len);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        mode        <= m;
        address     <= a;
        address_ok  <= ok;
        kind_bits   <= k;
        access_kind <= acc;
        length      <= len;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic random_command();
        int          sel;
        int          p;
        logic [2:0]  m;
        logic [63:0] a;
        sel = $urandom_range(99);
        p   = $urandom_range(23);
        if (sel < 35)      m = OP_ADD;
        else if (sel < 55) m = OP_REMOVE;
        else if (sel < 65) m = OP_HAS;
        else if (sel < 75) m = OP_HIT;
        else if (sel < 82) m = OP_ENABLE;
        else if (sel < 89) m = OP_DISABLE;
        else if (sel < 92) m = OP_CLEAR;
        else if (sel < 94) m = 3'd7;
        else               m = OP_ADD;
        a = ($urandom_range(9) == 0) ? {$urandom, $urandom} : addr_pool[p];
        issue(m, a, $urandom_range(9) != 0,
              ($urandom_range(2) == 0) ? kTypePermanent : 3'($urandom_range(7)),
              ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'(p % 4),
              4'($urandom_range(15)));
    endtask

    initial begin
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 24; i++)
            addr_pool[i] = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue(OP_ENABLE,  '0, 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_DISABLE, '0, 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_ADD,     addr_pool[1], 1'b1, kTypePermanent, 2'd3, 4'd15);
        issue(OP_ADD,     addr_pool[0], 1'b1, kTypeTemporaryOneShot, 2'd0, 4'd0);
        issue(OP_ADD,     addr_pool[2], 1'b1, kTypeTemporaryUntilHit, 2'd1, 4'd8);
        issue(OP_ADD,     addr_pool[1], 1'b1, kTypePermanent, 2'd0, 4'd1);
        issue(OP_ADD,     addr_pool[1], 1'b0, kTypePermanent, 2'd3, 4'd1);
        issue(OP_ADD,     addr_pool[1], 1'b1, 3'd6, 2'd3, 4'd1);
        issue(OP_HAS,     addr_pool[2], 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_HAS,     addr_pool[3], 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_HIT,     addr_pool[2], 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_HIT,     addr_pool[2], 1'b0, 3'd0, 2'd0, 4'd0);
        issue(OP_ENABLE,  '0, 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_ADD,     addr_pool[4], 1'b1, 3'd7, 2'd2, 4'd4);
        issue(OP_REMOVE,  addr_pool[1], 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_REMOVE,  addr_pool[1], 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_REMOVE,  addr_pool[5], 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_REMOVE,  addr_pool[4], 1'b0, 3'd0, 2'd0, 4'd0);
        issue(OP_DISABLE, '0, 1'b1, 3'd0, 2'd0, 4'd0);
        issue(3'd7,       addr_pool[0], 1'b1, 3'd0, 2'd0, 4'd0);
        for (int i = 0; i < 17; i++)
            issue(OP_ADD, addr_pool[6 + i], 1'b1, kTypeTemporaryOneShot, 2'd1, 4'd2);
        issue(OP_ENABLE,  '0, 1'b1, 3'd0, 2'd0, 4'd0);
        issue(OP_CLEAR,   '0, 1'b1, 3'd0, 2'd0, 4'd0);
        for (int i = 0; i < 3; i++)
            issue(OP_ADD, addr_pool[3], 1'b1, kTypePermanent, 2'd3, 4'd3);
        issue(OP_CLEAR,   '0, 1'b1, 3'd0, 2'd0, 4'd0);

        start <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 85 : (phase == 3) ? 14 : 0;
            repeat (15) random_command();
        end
        start <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("breakpoint_site_table_test passed");
        else
            $display("breakpoint_site_table_test failed");
        $finish;
    end
endmodule

/* breakpoint_site_table.f */
src/bst_pkg.sv
src/bst_site_mem.sv
src/breakpoint_site_table.sv
src/bst_checker.sv
tb/sv/breakpoint_site_table_checker.sv
tb/sv/breakpoint_site_table_test.sv
